### design/bbz_pkg.sv
// Shared constants, register codes and stage types for the box blur.
package bbz_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_RADIUS = 7;
	localparam int MAX_ROWS   = 1024;
	localparam int PIX_W      = 8;

	localparam int RING_LINES = 2 * MAX_RADIUS + 1;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int CNT_W      = $clog2(MAX_COLS + MAX_RADIUS);
	localparam int ROW_W      = $clog2(MAX_ROWS + MAX_RADIUS);
	localparam int RING_W     = $clog2(RING_LINES);
	localparam int R_EFF_W    = $clog2(MAX_RADIUS + 1);
	localparam int LINE_DEPTH = RING_LINES * MAX_COLS;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int PIX_MAX    = (1 << PIX_W) - 1;
	localparam int CS_W       = $clog2(RING_LINES * PIX_MAX + 1);
	localparam int MAX_SUM    = RING_LINES * RING_LINES * PIX_MAX;

	// fixed field widths of the register and result ports
	localparam int DIM_W      = 11;
	localparam int RAD_W      = 3;
	localparam int RECIP_W    = 25;
	localparam int CFG_DATA_W = 25;
	localparam int CFG_IDX_W  = 2;
	localparam int SUM_W      = 16;
	localparam int AVG_W      = 16;
	localparam int FRAC_SHIFT = 16;
	localparam int PROD_W     = SUM_W + RECIP_W;

	localparam logic [DIM_W-1:0]   ROWS_RST   = DIM_W'(1024);
	localparam logic [DIM_W-1:0]   COLS_RST   = DIM_W'(1024);
	localparam logic [RAD_W-1:0]   RADIUS_RST = RAD_W'(1);
	localparam logic [RECIP_W-1:0] RECIP_RST  = RECIP_W'(1864135);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS   = 2'd0,
		CFG_COLS   = 2'd1,
		CFG_RADIUS = 2'd2,
		CFG_RECIP  = 2'd3
	} cfg_reg_t;

	// one accepted beat, decoded against the raster position
	typedef struct packed {
		logic                    col_ok;
		logic [PIX_W-1:0]        pix;
		logic                    cs_en;
		logic                    old_en;
		logic                    sub_en;
		logic                    first;
		logic                    res;
		logic                    last;
		logic [RING_W-1:0]       tap;
		logic [COL_W-1:0]        col_addr;
		logic [LINE_AW-1:0]      line_addr;
	} raster_item_t;

endpackage

### design/bbz_raster.sv
// Configuration registers and extended raster counters; decodes each beat.
module bbz_raster import bbz_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	input  logic                  action,
	input  logic [PIX_W-1:0]      pixel_value,
	output raster_item_t          item,
	output logic [RECIP_W-1:0]    recip
);

	logic [DIM_W-1:0]   rows_q;
	logic [DIM_W-1:0]   cols_q;
	logic [RAD_W-1:0]   radius_q;
	logic [RECIP_W-1:0] recip_q;

	logic [CNT_W-1:0]   ic_q;
	logic [ROW_W-1:0]   ir_q;
	logic [RING_W-1:0]  ring_q;

	logic [ROW_W-1:0]   rows_eff;
	logic [CNT_W-1:0]   cols_eff;
	logic [R_EFF_W-1:0] r_eff;
	logic [RING_W-1:0]  ring_top;
	logic               col_end;
	logic               row_end;

	always_comb begin
		if (rows_q == '0) begin
			rows_eff = ROW_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_eff = ROW_W'(MAX_ROWS);
		end else begin
			rows_eff = ROW_W'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = CNT_W'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			cols_eff = CNT_W'(MAX_COLS);
		end else begin
			cols_eff = CNT_W'(cols_q);
		end
		if (int'(radius_q) > MAX_RADIUS) begin
			r_eff = R_EFF_W'(MAX_RADIUS);
		end else begin
			r_eff = R_EFF_W'(radius_q);
		end
	end

	// span - 1 is both the last ring line and the tap of the leaving column
	assign ring_top = RING_W'(2 * int'(r_eff));
	assign col_end  = (ic_q == cols_eff + CNT_W'(r_eff) - CNT_W'(1));
	assign row_end  = (ir_q == rows_eff + ROW_W'(r_eff) - ROW_W'(1));

	always_comb begin
		item.col_ok   = (ic_q < cols_eff);
		item.pix      = ((ir_q < rows_eff) && !action) ? pixel_value : '0;
		item.cs_en    = (ir_q != '0);
		item.old_en   = (ir_q > ROW_W'(ring_top));
		item.sub_en   = (ic_q > CNT_W'(ring_top));
		item.first    = (ic_q == '0);
		item.res      = (ir_q >= ROW_W'(r_eff)) && (ic_q >= CNT_W'(r_eff));
		item.last     = col_end && row_end;
		item.tap      = ring_top;
		item.col_addr = ic_q[COL_W-1:0];
		item.line_addr = LINE_AW'(ring_q) * LINE_AW'(MAX_COLS) + LINE_AW'(ic_q[COL_W-1:0]);
	end

	assign recip = recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RST;
			cols_q   <= COLS_RST;
			radius_q <= RADIUS_RST;
			recip_q  <= RECIP_RST;
			ic_q     <= '0;
			ir_q     <= '0;
			ring_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROWS:   rows_q   <= cfg_data[DIM_W-1:0];
				CFG_COLS:   cols_q   <= cfg_data[DIM_W-1:0];
				CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				CFG_RECIP:  recip_q  <= cfg_data[RECIP_W-1:0];
				default: ;
			endcase
			// restart the frame on any register write
			ic_q   <= '0;
			ir_q   <= '0;
			ring_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				ic_q <= '0;
				if (row_end) begin
					ir_q   <= '0;
					ring_q <= '0;
				end else begin
					ir_q   <= ir_q + ROW_W'(1);
					ring_q <= (ring_q == ring_top) ? '0 : ring_q + RING_W'(1);
				end
			end else begin
				ic_q <= ic_q + CNT_W'(1);
			end
		end
	end

endmodule

### design/bbz_window.sv
// Line store, column sums and running horizontal sum; one beat per clock while not stalled.
module bbz_window import bbz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  raster_item_t       item,
	output logic               in_ready,
	output logic               sum_valid,
	input  logic               sum_ready,
	output logic [SUM_W-1:0]   sum,
	output logic               sum_last
);

	logic [PIX_W-1:0] line_mem [LINE_DEPTH];
	logic [CS_W-1:0]  col_mem  [MAX_COLS];
	logic [CS_W-1:0]  taps_q   [RING_LINES];

	logic               s1_valid_q;
	raster_item_t       s1_item_q;
	logic [CS_W-1:0]    col_rd_s1;
	logic [PIX_W-1:0]   line_rd_s1;

	logic               s2_valid_q;
	logic [SUM_W-1:0]   s2_sum_q;
	logic               s2_last_q;

	logic [SUM_W-1:0]   hsum_q;

	logic               s2_free;
	logic               s1_adv;
	logic               wr_en;
	logic [CS_W-1:0]    cs;
	logic [CS_W-1:0]    cs_push;
	logic [SUM_W-1:0]   h_base;
	logic [SUM_W-1:0]   h_sub;
	logic [SUM_W-1:0]   h_new;

	assign s2_free  = !s2_valid_q || sum_ready;
	assign s1_adv   = s1_valid_q && (!s1_item_q.res || s2_free);
	assign in_ready = !s1_valid_q || s1_adv;
	assign wr_en    = s1_adv && s1_item_q.col_ok;

	always_comb begin
		cs = (s1_item_q.cs_en ? col_rd_s1 : '0)
			- (s1_item_q.old_en ? CS_W'(line_rd_s1) : '0)
			+ CS_W'(s1_item_q.pix);
		cs_push = s1_item_q.col_ok ? cs : '0;
		h_base  = s1_item_q.first ? '0 : hsum_q;
		// drop the column that left the window span beats ago
		h_sub   = s1_item_q.sub_en ? SUM_W'(taps_q[s1_item_q.tap]) : '0;
		h_new   = h_base + SUM_W'(cs_push) - h_sub;
	end

	// stores: write from s1, read for the beat being accepted, write-first
	always_ff @(posedge clk) begin
		if (wr_en) begin
			col_mem[s1_item_q.col_addr]   <= cs;
			line_mem[s1_item_q.line_addr] <= s1_item_q.pix;
		end
		if (accept) begin
			if (wr_en && (s1_item_q.col_addr == item.col_addr)) begin
				col_rd_s1 <= cs;
			end else begin
				col_rd_s1 <= col_mem[item.col_addr];
			end
			if (wr_en && (s1_item_q.line_addr == item.line_addr)) begin
				line_rd_s1 <= s1_item_q.pix;
			end else begin
				line_rd_s1 <= line_mem[item.line_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_item_q <= item;
		end
		if (s1_adv) begin
			taps_q[0] <= cs_push;
			for (int i = 1; i < RING_LINES; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
		if (s1_adv && s1_item_q.res) begin
			s2_sum_q  <= h_new;
			s2_last_q <= s1_item_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			hsum_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				hsum_q <= h_new;
			end
			if (s1_adv && s1_item_q.res) begin
				s2_valid_q <= 1'b1;
			end else if (sum_ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	assign sum_valid = s2_valid_q;
	assign sum       = s2_sum_q;
	assign sum_last  = s2_last_q;

endmodule

### design/bbz_scale.sv
// Reciprocal multiply to Q8.8, saturation and the output register.
module bbz_scale import bbz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sum_valid,
	output logic               sum_ready,
	input  logic [SUM_W-1:0]   sum,
	input  logic               sum_last,
	input  logic [RECIP_W-1:0] recip,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [SUM_W-1:0]   window_sum,
	output logic [AVG_W-1:0]   blur_average,
	output logic               frame_last
);

	logic               out_valid_q;
	logic [SUM_W-1:0]   sum_s3;
	logic [AVG_W-1:0]   avg_s3;
	logic               last_s3;
	logic [PROD_W-1:0]  prod;
	logic [AVG_W-1:0]   avg_sat;

	assign sum_ready = !out_valid_q || out_ready;

	always_comb begin
		prod = PROD_W'(sum) * PROD_W'(recip);
		// clamp the Q8.8 average to the result width
		if (|prod[PROD_W-1:FRAC_SHIFT+AVG_W]) begin
			avg_sat = '1;
		end else begin
			avg_sat = prod[FRAC_SHIFT+AVG_W-1:FRAC_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) begin
			sum_s3  <= sum;
			avg_s3  <= avg_sat;
			last_s3 <= sum_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sum_valid && sum_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_sum   = sum_s3;
	assign blur_average = avg_s3;
	assign frame_last   = last_s3;

endmodule

### design/box_blur_zero_padded.sv
// Streaming box blur with zero padding: top level.
//
// Input beats arrive on in_valid/in_ready in raster order, one per extended
// raster position: each frame line is followed by r flush beats (action = 1)
// and the frame by r lines of flush beats. Every beat at line >= r and
// column >= r yields one result on out_valid/out_ready: the exact window sum,
// the average in Q8.8 (sum times area_reciprocal, shifted down 16) and
// frame_last on the frame's final pixel. Other beats yield nothing.
// Throughput is one beat per clock while the output is not stalled, set by
// the combinational update of the running horizontal sum and one read plus
// one write per store each clock. When the receiver stalls, the result
// register holds its beat and the two stages behind it keep filling;
// in_ready drops once all three are full and s1 holds a result beat.
// Registers are written on cfg_valid (cfg_ready is always high) while the
// block is idle; the user must ensure this, the block does not enforce it.
// Any write restarts the frame at position zero. Reset restores the register
// defaults and clears counters and stage valids. No clearing pass runs:
// column sums and lines are read only after the current frame wrote them.
module box_blur_zero_padded import bbz_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [PIX_W-1:0]      pixel_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SUM_W-1:0]      window_sum,
	output logic [AVG_W-1:0]      blur_average,
	output logic                  frame_last
);

	raster_item_t       item;
	logic [RECIP_W-1:0] recip;
	logic               accept;
	logic               sum_valid;
	logic               sum_ready;
	logic [SUM_W-1:0]   sum;
	logic               sum_last;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	bbz_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.action      (action),
		.pixel_value (pixel_value),
		.item        (item),
		.recip       (recip)
	);

	bbz_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.in_ready  (in_ready),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum),
		.sum_last  (sum_last)
	);

	bbz_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum_valid    (sum_valid),
		.sum_ready    (sum_ready),
		.sum          (sum),
		.sum_last     (sum_last),
		.recip        (recip),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_sum   (window_sum),
		.blur_average (blur_average),
		.frame_last   (frame_last)
	);

endmodule

### design/bbz_checker.sv
// Port-level checks for the box blur, bound to the top level.
module bbz_checker import bbz_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [SUM_W-1:0] window_sum,
	input logic [AVG_W-1:0] blur_average,
	input logic             frame_last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_sum)
			&& $stable(blur_average) && $stable(frame_last))
		else $error("result beat changed while stalled");

	// an empty result register never backs up the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_sum <= SUM_W'(MAX_SUM))
		else $error("window sum above full window maximum");

	a_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (window_sum == '0) |-> blur_average == '0)
		else $error("nonzero average for zero sum");

endmodule

bind box_blur_zero_padded bbz_checker u_bbz_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.window_sum   (window_sum),
	.blur_average (blur_average),
	.frame_last   (frame_last)
);

### dv/box_blur_zero_padded_tb.sv
// Self-checking testbench for the zero-padded streaming box blur.
`timescale 1ns / 100ps

module box_blur_zero_padded_tb;
	import bbz_pkg::*;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   RANDOM_BEATS = 1000;
	localparam int   CLAMP_BEATS = 24;
	localparam int   NUM_DIRECTED = 30;
	localparam logic [CFG_DATA_W-1:0] RECIP_UNITY = CFG_DATA_W'(1 << 24);
	localparam logic [CFG_DATA_W-1:0] DIM_ALL_ONES = CFG_DATA_W'(11'h7FF);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [AVG_W-1:0] avg;
		logic             last;
	} blur_res_t;

	typedef enum logic {STEP_BEAT, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		cfg_reg_t              idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  act;
		logic [PIX_W-1:0]      pix;
		logic                  given;
		logic [SUM_W-1:0]      sum;
		logic [AVG_W-1:0]      avg;
		logic                  last;
	} dir_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = CFG_ROWS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  action = ACT_PIXEL;
	logic [PIX_W-1:0]      pixel_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SUM_W-1:0]      window_sum;
	logic [AVG_W-1:0]      blur_average;
	logic                  frame_last;

	// predictor state
	logic [PIX_W-1:0]   line_mem [LINE_DEPTH];
	logic [CS_W-1:0]    col_sum [MAX_COLS];
	int unsigned        hsum = 0;
	int unsigned        in_row = 0;
	int unsigned        in_col = 0;
	logic [DIM_W-1:0]   rows_reg = ROWS_RST;
	logic [DIM_W-1:0]   cols_reg = COLS_RST;
	logic [RAD_W-1:0]   rad_reg = RADIUS_RST;
	logic [RECIP_W-1:0] recip_reg = RECIP_RST;

	blur_res_t want_results [$];
	int send_idle = 17;
	int recv_idle = 71;
	int beats_fed = 0;
	int writes_done = 0;
	int results_checked = 0;
	int frames_closed = 0;
	int fail_count = 0;

	dir_step_t directed_steps [NUM_DIRECTED] = '{
		'{STEP_WRITE, CFG_ROWS,   25'd1,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_WRITE, CFG_COLS,   25'd1,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_WRITE, CFG_RADIUS, 25'd0,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_WRITE, CFG_RECIP,  25'd16777216, ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd0,   1'b1, 16'd0,   16'd0,     1'b1},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd255, 1'b1, 16'd255, 16'd65280, 1'b1},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd170, 1'b1, 16'd170, 16'd43520, 1'b1},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd85,  1'b1, 16'd85,  16'd21760, 1'b1},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_FLUSH, 8'd255, 1'b1, 16'd0,   16'd0,     1'b1},
		'{STEP_WRITE, CFG_RECIP,  25'd0,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd255, 1'b1, 16'd255, 16'd0,     1'b1},
		'{STEP_WRITE, CFG_RECIP,  25'd33554431, ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd255, 1'b1, 16'd255, 16'd65535, 1'b1},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd1,   1'b1, 16'd1,   16'd511,   1'b1},
		'{STEP_WRITE, CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_WRITE, CFG_COLS,   25'd0,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd7,   1'b1, 16'd7,   16'd3583,  1'b1},
		'{STEP_WRITE, CFG_RADIUS, 25'd1,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_WRITE, CFG_RECIP,  25'd1864135,  ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd50,  1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_FLUSH, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		// restart in the middle of a frame
		'{STEP_WRITE, CFG_ROWS,   25'd1,        ACT_PIXEL, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd9,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_FLUSH, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_FLUSH, 8'd0,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_FLUSH, 8'd0,   1'b1, 16'd9,   16'd255,   1'b1},
		// pixels on padding positions must be ignored
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd4,   1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd200, 1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd200, 1'b0, 16'd0,   16'd0,     1'b0},
		'{STEP_BEAT,  CFG_ROWS,   25'd0,        ACT_PIXEL, 8'd200, 1'b1, 16'd4,   16'd113,   1'b1}
	};

	box_blur_zero_padded uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.pixel_value  (pixel_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.window_sum   (window_sum),
		.blur_average (blur_average),
		.frame_last   (frame_last)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic int unsigned eff_rows();
		int unsigned n;
		n = rows_reg;
		return (n == 0) ? 1 : ((n > MAX_ROWS) ? MAX_ROWS : n);
	endfunction

	function automatic int unsigned eff_cols();
		int unsigned n;
		n = cols_reg;
		return (n == 0) ? 1 : ((n > MAX_COLS) ? MAX_COLS : n);
	endfunction

	function automatic int unsigned eff_radius();
		int unsigned n;
		n = rad_reg;
		return (n > MAX_RADIUS) ? MAX_RADIUS : n;
	endfunction

	// advance one extended-raster position; returns 1 when a result is due
	function automatic bit blur_window_predict(input logic act, input logic [PIX_W-1:0] pix,
			output blur_res_t res);
		int unsigned rows, cols, r, span, ir, ic, v, slot, prior, cs;
		longint unsigned scaled;
		bit got;
		rows = eff_rows();
		cols = eff_cols();
		r = eff_radius();
		span = 2 * r + 1;
		ir = in_row;
		ic = in_col;
		got = 1'b0;
		res = '0;
		if (ic == 0)
			hsum = 0;
		if (ic < cols) begin
			v = (ir < rows && act == ACT_PIXEL) ? pix : 0;
			slot = (ir % span) * MAX_COLS + ic;
			prior = (ir >= span) ? line_mem[slot] : 0;
			cs = (ir == 0) ? 0 : col_sum[ic];
			cs = cs - prior + v;
			col_sum[ic] = CS_W'(cs);
			line_mem[slot] = PIX_W'(v);
			hsum += cs;
		end
		if (ic >= span && ic - span < cols)
			hsum -= col_sum[ic - span];
		if (ir >= r && ic >= r) begin
			scaled = (longint'(hsum) * longint'(recip_reg)) >> FRAC_SHIFT;
			res.sum = (hsum > 32'hFFFF) ? '1 : SUM_W'(hsum);
			res.avg = (scaled > 64'hFFFF) ? '1 : AVG_W'(scaled);
			res.last = (ir - r == rows - 1) && (ic - r == cols - 1);
			got = 1'b1;
		end
		if (ic + 1 < cols + r) begin
			in_col = ic + 1;
		end else begin
			in_col = 0;
			in_row = (ir + 1 < rows + r) ? ir + 1 : 0;
		end
		return got;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch: %s", $realtime, msg);
	endfunction

	// wait for the block to go idle, then write one register
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (want_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ROWS:   rows_reg = DIM_W'(val);
			CFG_COLS:   cols_reg = DIM_W'(val);
			CFG_RADIUS: rad_reg = RAD_W'(val);
			CFG_RECIP:  recip_reg = RECIP_W'(val);
			default: ;
		endcase
		hsum = 0;
		in_row = 0;
		in_col = 0;
		writes_done++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic feed_raster_beat(input logic act, input logic [PIX_W-1:0] pix,
			input logic given, input blur_res_t given_res);
		blur_res_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pixel_value <= pix;
		do @(posedge clk); while (!in_ready);
		if (blur_window_predict(act, pix, res))
			want_results.push_back(given ? given_res : res);
		beats_fed++;
	endtask

	// mostly well-formed: pixels inside the frame, flushes on padding
	task automatic run_beats(input int count);
		logic act;
		for (int k = 0; k < count; k++) begin
			act = (in_row < eff_rows() && in_col < eff_cols()) ? ACT_PIXEL : ACT_FLUSH;
			if ($urandom_range(99) < 8)
				act = ~act;
			feed_raster_beat(act, PIX_W'($urandom), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : result_check
		blur_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (frame_last)
				frames_closed++;
			if (want_results.size() == 0) begin
				note_failure($sformatf("unexpected result sum %0d avg %0d last %0b",
					window_sum, blur_average, frame_last));
			end else begin
				want = want_results.pop_front();
				if (window_sum !== want.sum || blur_average !== want.avg ||
						frame_last !== want.last)
					note_failure($sformatf(
						"result %0d: sum %0d/%0d avg %0d/%0d last %0b/%0b (want/got)",
						results_checked, want.sum, window_sum, want.avg, blur_average,
						want.last, frame_last));
			end
		end
	end

	initial begin
		dir_step_t step;
		blur_res_t given_res;
		int rand_base, done_beats, phase, rows_n, cols_n, rad_n, span_n, ext;
		logic [CFG_DATA_W-1:0] recip_n, hi;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			step = directed_steps[i];
			if (step.kind == STEP_WRITE) begin
				write_reg(step.idx, step.data);
			end else begin
				given_res = '{step.sum, step.avg, step.last};
				feed_raster_beat(step.act, step.pix, step.given, given_res);
			end
		end

		// row clamp: one column, all-ones row count
		write_reg(CFG_ROWS, DIM_ALL_ONES);
		write_reg(CFG_COLS, CFG_DATA_W'(1));
		write_reg(CFG_RADIUS, '0);
		write_reg(CFG_RECIP, RECIP_UNITY);
		run_beats(CLAMP_BEATS);
		// column clamp: one row, all-ones column count
		write_reg(CFG_ROWS, CFG_DATA_W'(1));
		write_reg(CFG_COLS, DIM_ALL_ONES);
		run_beats(CLAMP_BEATS);

		rand_base = beats_fed;
		phase = 0;
		while (beats_fed - rand_base < RANDOM_BEATS) begin
			done_beats = beats_fed - rand_base;
			if (done_beats < RANDOM_BEATS / 3) begin
				send_idle = 17;
				recv_idle = 71;
			end else if (done_beats < 2 * RANDOM_BEATS / 3) begin
				send_idle = 71;
				recv_idle = 17;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			rows_n = ($urandom_range(19) == 0) ? 0 : $urandom_range(12, 1);
			cols_n = ($urandom_range(19) == 0) ? 0 : $urandom_range(12, 1);
			rad_n = $urandom_range(MAX_RADIUS);
			span_n = 2 * rad_n + 1;
			if ($urandom_range(4) == 0)
				recip_n = CFG_DATA_W'($urandom);
			else
				recip_n = CFG_DATA_W'(((1 << 24) + span_n * span_n / 2) / (span_n * span_n));
			// junk above the field width must be dropped
			hi = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) : '0;
			if (phase == 0 || $urandom_range(3) != 0)
				write_reg(CFG_ROWS, (hi << DIM_W) | CFG_DATA_W'(rows_n));
			if (phase == 0 || $urandom_range(3) != 0)
				write_reg(CFG_COLS, (hi << DIM_W) | CFG_DATA_W'(cols_n));
			if (phase == 0 || $urandom_range(3) != 0)
				write_reg(CFG_RADIUS, (hi << RAD_W) | CFG_DATA_W'(rad_n));
			if (phase == 0 || $urandom_range(3) != 0)
				write_reg(CFG_RECIP, recip_n);
			ext = (eff_rows() + eff_radius()) * (eff_cols() + eff_radius());
			if ($urandom_range(3) == 0)
				run_beats($urandom_range(ext, 1));
			else
				run_beats(ext * $urandom_range(2, 1));
			phase++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (want_results.size() != 0)
			@(negedge clk);
		repeat (2 * DRAIN_CYCLES) @(negedge clk);

		$display("fed %0d beats (%0d in random settings) with %0d register writes",
			beats_fed, beats_fed - rand_base, writes_done);
		$display("checked %0d results over %0d completed frames, %0d failures",
			results_checked, frames_closed, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout: block stopped making progress");
		$display("status: fail");
		$finish;
	end

endmodule

### sim.f
design/bbz_pkg.sv
design/bbz_raster.sv
design/bbz_window.sv
design/bbz_scale.sv
design/box_blur_zero_padded.sv
design/bbz_checker.sv
dv/box_blur_zero_padded_tb.sv
